### hw/rtl/id3v2_text_frame_extractor_macros.svh
// Assertion macros shared by the text frame extractor RTL.
// Uses the including module's i_clk and active-low i_rst_n.
`ifndef ID3V2_TEXT_FRAME_EXTRACTOR_MACROS_SVH
`define ID3V2_TEXT_FRAME_EXTRACTOR_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ID3TFE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define ID3TFE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/id3tfe_pkg.sv
// Types, constants and the frame ID lookup for the text frame extractor.
// No dependencies; imported by every RTL module of the block.
package id3tfe_pkg;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_IDENT,
        PH_SIZE,
        PH_FLAGS,
        PH_ENC,
        PH_BODY,
        PH_STOP
    } t_phase;

    localparam int unsigned KIND_COUNT = 6;

    localparam logic [3:0] HEADER_LAST    = 4'd9;  // tag header is 10 bytes
    localparam logic [3:0] WORD_LAST      = 4'd3;  // ID and size are 4 bytes
    localparam logic [3:0] FLAGS_LAST     = 4'd1;  // two flag bytes
    localparam logic [3:0] COMMENT_SKIP   = 4'd4;  // language code + separator
    localparam logic [3:0] COUNT_MAX      = 4'd15;
    localparam logic [3:0] MAX_FRAMES_RST = 4'd6;

    localparam logic [2:0] KIND_TITLE   = 3'd0;
    localparam logic [2:0] KIND_COMMENT = 3'd5;

    localparam logic [31:0] KIND_IDS [KIND_COUNT] = '{
        32'h5449_5432,  // TIT2
        32'h5450_4531,  // TPE1
        32'h5441_4C42,  // TALB
        32'h5459_4552,  // TYER
        32'h5443_4F4E,  // TCON
        32'h434F_4D4D   // COMM
    };

    typedef struct packed {
        logic [2:0] frame_kind;
        logic [7:0] text_byte;
        logic       has_char;
        logic       last;
    } t_result;

    typedef struct packed {
        logic       hit;
        logic [2:0] kind;
    } t_match;

    // Look the frame ID up in the selected ID list
    function automatic t_match match_kind(input logic [31:0] ident);
        t_match m;
        m.hit  = 1'b0;
        m.kind = KIND_TITLE;
        for (int k = 0; k < KIND_COUNT; k++) begin
            if (ident == KIND_IDS[k]) begin
                m.hit  = 1'b1;
                m.kind = 3'(k);
            end
        end
        return m;
    endfunction

endpackage

### hw/rtl/id3tfe_parser.sv
// Frame parser: walks tag header and frame fields, selects text frames.
// Depends on id3tfe_pkg; one byte per accepted beat, result is combinational.
module id3tfe_parser import id3tfe_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_data_byte,
    input  logic          i_file_start,
    input  logic [3:0]    i_max_frames,
    output logic          o_res_valid,
    output t_result       o_res
);

    t_phase       r_phase, n_phase;
    logic [3:0]   r_pos, n_pos;
    logic [31:0]  r_ident, n_ident;
    logic [31:0]  r_length, n_length;
    logic [31:0]  r_remain, n_remain;
    logic [2:0]   r_kind, n_kind;
    logic         r_sel, n_sel;
    logic [3:0]   r_count, n_count;
    logic         r_zero, n_zero;

    // State as seen by this beat: a file start clears the parse first
    t_phase       c_phase;
    logic [3:0]   c_pos;
    logic [3:0]   c_count;
    logic [31:0]  size_word;
    t_match       match;
    logic [3:0]   skip;
    logic         past_skip;
    logic         body_last;
    logic         body_take;

    assign c_phase   = i_file_start ? PH_HEADER : r_phase;
    assign c_pos     = i_file_start ? 4'd0 : r_pos;
    assign c_count   = i_file_start ? 4'd0 : r_count;
    assign size_word = {r_length[23:0], i_data_byte};
    assign match     = match_kind(r_ident);
    assign skip      = (r_kind == KIND_COMMENT) ? COMMENT_SKIP : 4'd0;
    assign past_skip = (r_pos >= skip);
    assign body_last = (r_remain == 32'd0);
    assign body_take = r_sel && past_skip && !r_zero;

    // Next phase
    always_comb begin
        n_phase = c_phase;
        case (c_phase)
            PH_HEADER: begin
                if (c_pos == HEADER_LAST) n_phase = PH_IDENT;
            end
            PH_IDENT: begin
                if (c_pos == 4'd0 && c_count >= i_max_frames) n_phase = PH_STOP;
                else if (c_pos == WORD_LAST)                  n_phase = PH_SIZE;
            end
            PH_SIZE: begin
                if (c_pos == WORD_LAST) begin
                    n_phase = (size_word == 32'd0) ? PH_STOP : PH_FLAGS;
                end
            end
            PH_FLAGS: begin
                if (c_pos == FLAGS_LAST) n_phase = PH_ENC;
            end
            PH_ENC: begin
                n_phase = (r_length == 32'd1) ? PH_IDENT : PH_BODY;
            end
            PH_BODY: begin
                if (body_last) n_phase = PH_IDENT;
            end
            PH_STOP: begin
                n_phase = PH_STOP;
            end
            default: begin
                n_phase = PH_STOP;
            end
        endcase
    end

    // Field registers and the result of this beat
    always_comb begin
        n_pos       = c_pos;
        n_ident     = r_ident;
        n_length    = r_length;
        n_remain    = r_remain;
        n_kind      = r_kind;
        n_sel       = r_sel;
        n_count     = c_count;
        n_zero      = r_zero;
        o_res_valid = 1'b0;
        o_res       = '{frame_kind: r_kind, text_byte: 8'd0, has_char: 1'b0, last: 1'b0};
        case (c_phase)
            PH_HEADER: begin
                n_pos = (c_pos == HEADER_LAST) ? 4'd0 : c_pos + 4'd1;
            end
            PH_IDENT: begin
                if (!(c_pos == 4'd0 && c_count >= i_max_frames)) begin
                    n_ident = {r_ident[23:0], i_data_byte};
                    n_pos   = (c_pos == WORD_LAST) ? 4'd0 : c_pos + 4'd1;
                end
            end
            PH_SIZE: begin
                n_length = size_word;
                n_pos    = (c_pos == WORD_LAST) ? 4'd0 : c_pos + 4'd1;
            end
            PH_FLAGS: begin
                n_pos = (c_pos == FLAGS_LAST) ? 4'd0 : c_pos + 4'd1;
            end
            PH_ENC: begin
                n_sel    = match.hit;
                n_kind   = match.kind;
                n_zero   = 1'b0;
                n_pos    = 4'd0;
                n_remain = r_length - 32'd2;
                if (r_length == 32'd1) begin
                    // Empty payload: close the frame right here
                    if (match.hit && c_count < COUNT_MAX) n_count = c_count + 4'd1;
                    o_res_valid = match.hit;
                    o_res = '{frame_kind: match.kind, text_byte: 8'd0,
                              has_char: 1'b0, last: 1'b1};
                end
            end
            PH_BODY: begin
                o_res.last = body_last;
                if (body_take) begin
                    if (i_data_byte == 8'd0) begin
                        n_zero = 1'b1;
                    end else begin
                        o_res.has_char  = 1'b1;
                        o_res.text_byte = i_data_byte;
                    end
                end
                o_res_valid = r_sel && (o_res.has_char || body_last);
                n_remain    = r_remain - 32'd1;
                if (r_pos < COMMENT_SKIP) n_pos = r_pos + 4'd1;
                if (body_last) begin
                    n_pos = 4'd0;
                    if (r_sel && c_count < COUNT_MAX) n_count = c_count + 4'd1;
                end
            end
            PH_STOP: begin
                n_pos = c_pos;
            end
            default: begin
                n_pos = c_pos;
            end
        endcase
    end

    // Advance the parse on every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= 4'd0;
            r_ident  <= 32'd0;
            r_length <= 32'd0;
            r_remain <= 32'd0;
            r_kind   <= KIND_TITLE;
            r_sel    <= 1'b0;
            r_count  <= 4'd0;
            r_zero   <= 1'b0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_ident  <= n_ident;
            r_length <= n_length;
            r_remain <= n_remain;
            r_kind   <= n_kind;
            r_sel    <= n_sel;
            r_count  <= n_count;
            r_zero   <= n_zero;
        end
    end

endmodule

### hw/rtl/id3tfe_out_reg.sv
// Result register between the parser and the output channel.
// Depends on id3tfe_pkg for the result struct.
module id3tfe_out_reg import id3tfe_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_take,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_load_ok,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // Room for a new result when empty or draining this cycle
    assign o_load_ok = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_res     = r_res;

    // Load a fresh result or drop the delivered one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load_ok) begin
            r_valid <= i_take && i_res_valid;
        end
    end

    // Hold the payload while stalled
    always_ff @(posedge i_clk) begin
        if (o_load_ok && i_take && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

### hw/rtl/id3v2_text_frame_extractor.sv
// A result appears in the output register in the cycle after its byte beat.
// Throughput: one byte per cycle while results are taken; a result left waiting in
// the output register stalls every byte, with or without a result, until it is taken.
// Reset (synchronous, active low) clears parse state, empties the output
// register and sets max_frames to 6. Depends on id3tfe_pkg and the macros header.
`include "id3v2_text_frame_extractor_macros.svh"

module id3v2_text_frame_extractor import id3tfe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_file_start,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_frame_kind,
    output logic [7:0] o_text_byte,
    output logic       o_has_char,
    output logic       o_last
);

    logic [3:0] r_max_frames;
    logic       take;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frames <= MAX_FRAMES_RST;
        end else if (i_cfg_we) begin
            r_max_frames <= i_cfg_wdata;
        end
    end

    assign take = i_valid && o_ready;

    id3tfe_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_data_byte  (i_data_byte),
        .i_file_start (i_file_start),
        .i_max_frames (r_max_frames),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    id3tfe_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_load_ok   (o_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (out_res)
    );

    assign o_frame_kind = out_res.frame_kind;
    assign o_text_byte  = out_res.text_byte;
    assign o_has_char   = out_res.has_char;
    assign o_last       = out_res.last;

    // A character result never carries the terminating zero
    `ID3TFE_ASSERT_IMP(a_char_nonzero, o_valid && o_has_char, o_text_byte != 8'd0, "zero text byte emitted")
    // A result without a character only closes a frame
    `ID3TFE_ASSERT_IMP(a_close_is_last, o_valid && !o_has_char, o_last && o_text_byte == 8'd0, "empty result without last")
    // Kind codes stay within the selected ID list
    `ID3TFE_ASSERT_IMP(a_kind_range, o_valid, o_frame_kind <= KIND_COMMENT, "frame kind out of range")
    // A result taken with no byte offered leaves the output free next cycle
    `ID3TFE_ASSERT_NXT(a_ready_after_drain, o_valid && i_ready && !i_valid, !o_valid && o_ready, "output did not drain")

endmodule

### tb/sv/id3_text_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the ID3v2 text frame extractor: tracks max_frames, predicts each text beat.
// Depends on id3tfe_pkg for the result type, phase enum and frame ID table.
module id3_text_checker import id3tfe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_file_start,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [2:0] i_frame_kind,
    input  logic [7:0] i_text_byte,
    input  logic       i_has_char,
    input  logic       i_last,
    output int         o_mismatches,
    output int         o_pending,
    output int         o_checked
);

    localparam int unsigned TAG_HEADER_BYTES = 10;
    localparam int unsigned WORD_BYTES       = 4;
    localparam int unsigned FLAG_BYTES       = 2;
    localparam int          REPORT_LIMIT     = 10;

    // Parser shadow state
    t_phase      phase;
    logic [31:0] pos;
    logic [31:0] ident;
    logic [31:0] flen;
    logic [2:0]  kind;
    logic        sel;
    logic        zero_seen;
    logic [3:0]  sel_count;
    logic [3:0]  max_frames;

    t_result text_due[$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    task automatic clear_parse();
        phase     = PH_HEADER;
        pos       = '0;
        ident     = '0;
        flen      = '0;
        kind      = '0;
        sel       = 1'b0;
        zero_seen = 1'b0;
        sel_count = '0;
    endtask

    task automatic close_frame();
        if (sel && sel_count < COUNT_MAX) begin
            sel_count = sel_count + 4'd1;
        end
        phase = PH_IDENT;
        pos   = '0;
    endtask

    task automatic push_text(input logic [7:0] ch, input logic has, input logic at_end);
        t_result r;
        r.frame_kind = kind;
        r.text_byte  = has ? ch : 8'h00;
        r.has_char   = has;
        r.last       = at_end;
        text_due.push_back(r);
    endtask

    // Advance the parser by one byte and queue the text beat it yields, if any
    task automatic advance_parser(input logic [7:0] b, input logic fs);
        logic [31:0] skip;
        logic        at_end;
        logic        has;
        if (fs) begin
            clear_parse();
        end
        case (phase)
            PH_HEADER: begin
                pos = pos + 1;
                if (pos >= TAG_HEADER_BYTES) begin
                    phase = PH_IDENT;
                    pos   = '0;
                end
            end
            PH_IDENT: begin
                // frame limit is checked only at the first ID byte
                if (pos == 0 && sel_count >= max_frames) begin
                    phase = PH_STOP;
                end else begin
                    ident = {ident[23:0], b};
                    pos   = pos + 1;
                    if (pos >= WORD_BYTES) begin
                        phase = PH_SIZE;
                        pos   = '0;
                        flen  = '0;
                    end
                end
            end
            PH_SIZE: begin
                flen = {flen[23:0], b};
                pos  = pos + 1;
                if (pos >= WORD_BYTES) begin
                    pos   = '0;
                    phase = (flen == 0) ? PH_STOP : PH_FLAGS;
                end
            end
            PH_FLAGS: begin
                pos = pos + 1;
                if (pos >= FLAG_BYTES) begin
                    phase = PH_ENC;
                    pos   = '0;
                end
            end
            PH_ENC: begin
                sel  = 1'b0;
                kind = '0;
                for (int k = 0; k < KIND_COUNT; k++) begin
                    if (ident == KIND_IDS[k]) begin
                        sel  = 1'b1;
                        kind = 3'(k);
                    end
                end
                zero_seen = 1'b0;
                pos       = '0;
                // a one-byte frame closes right on its encoding byte
                if (flen == 1) begin
                    if (sel) begin
                        push_text(8'h00, 1'b0, 1'b1);
                    end
                    close_frame();
                end else begin
                    phase = PH_BODY;
                end
            end
            PH_BODY: begin
                skip   = (kind == KIND_COMMENT) ? 32'(COMMENT_SKIP) : 32'd0;
                at_end = (pos == flen - 32'd2);
                has    = 1'b0;
                if (sel && pos >= skip && !zero_seen) begin
                    if (b == 8'h00) begin
                        zero_seen = 1'b1;
                    end else begin
                        has = 1'b1;
                    end
                end
                if (sel && (has || at_end)) begin
                    push_text(b, has, at_end);
                end
                pos = pos + 1;
                if (at_end) begin
                    close_frame();
                end
            end
            default: begin
                // stopped: drop everything until the next file start
            end
        endcase
    endtask

    task automatic note_mismatch(input string what, input t_result want, input t_result got);
        o_mismatches++;
        if (o_mismatches <= REPORT_LIMIT) begin
            $display("[%0t] %s: expected kind %0d byte %02h has %0b last %0b, got kind %0d byte %02h has %0b last %0b",
                     $realtime, what, want.frame_kind, want.text_byte, want.has_char, want.last,
                     got.frame_kind, got.text_byte, got.has_char, got.last);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            clear_parse();
            max_frames = MAX_FRAMES_RST;
            text_due.delete();
        end else begin
            if (i_cfg_we) begin
                max_frames = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) begin
                advance_parser(i_data_byte, i_file_start);
            end
            // compare each output beat with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                got.frame_kind = i_frame_kind;
                got.text_byte  = i_text_byte;
                got.has_char   = i_has_char;
                got.last       = i_last;
                o_checked++;
                if (text_due.size() == 0) begin
                    note_mismatch("unexpected beat", '0, got);
                end else begin
                    want = text_due.pop_front();
                    if (got.frame_kind !== want.frame_kind || got.text_byte !== want.text_byte ||
                        got.has_char !== want.has_char || got.last !== want.last) begin
                        note_mismatch("beat mismatch", want, got);
                    end
                end
            end
        end
        o_pending = text_due.size();
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the ID3v2 text frame extractor bench: clock, reset, file stimulus and verdict.
// Depends on id3tfe_pkg, the extractor RTL and id3_text_checker.
module testbench;
    import id3tfe_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int CHUNKS       = 12;
    localparam int CHUNK_BYTES  = 85;
    localparam int SETTLE       = 4;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
    localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
    localparam logic [31:0] ID_TALB = 32'h5441_4C42;
    localparam logic [31:0] ID_TYER = 32'h5459_4552;
    localparam logic [31:0] ID_TCON = 32'h5443_4F4E;
    localparam logic [31:0] ID_COMM = 32'h434F_4D4D;
    localparam logic [31:0] ID_TXXX = 32'h5458_5858;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_cfg_we     = 1'b0;
    logic [3:0] i_cfg_wdata  = '0;
    logic       i_valid      = 1'b0;
    logic       o_ready;
    logic [7:0] i_data_byte  = '0;
    logic       i_file_start = 1'b0;
    logic       o_valid;
    logic       i_ready      = 1'b0;
    logic [2:0] o_frame_kind;
    logic [7:0] o_text_byte;
    logic       o_has_char;
    logic       o_last;

    int mismatches;
    int pending;
    int checked;

    int send_idle = 33;
    int recv_idle = 83;
    bit hold_arm  = 1'b0;
    int cycle_count = 0;
    int bytes_sent  = 0;
    int files_sent  = 0;
    int cfg_writes  = 0;

    logic [7:0] file_bytes[$];

    id3v2_text_frame_extractor u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_file_start (i_file_start),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_frame_kind (o_frame_kind),
        .o_text_byte  (o_text_byte),
        .o_has_char   (o_has_char),
        .o_last       (o_last)
    );

    id3_text_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_data_byte  (i_data_byte),
        .i_file_start (i_file_start),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_frame_kind (o_frame_kind),
        .i_text_byte  (o_text_byte),
        .i_has_char   (o_has_char),
        .i_last       (o_last),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Watchdog: end the run if it hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off when armed
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (hold_arm) begin
                hold_arm  = 1'b0;
                hold_left = HOLD_CYCLES;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    function automatic logic [7:0] text_char();
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            return 8'h00;
        end else if (r < 70) begin
            return 8'($urandom_range(32, 126));
        end
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic put_word(input logic [31:0] w);
        for (int k = 3; k >= 0; k--) begin
            file_bytes.push_back(w[8*k +: 8]);
        end
    endtask

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            file_bytes.push_back(s[k]);
        end
    endtask

    // ID, size, two flag bytes and the encoding byte
    task automatic put_frame_head(input logic [31:0] id, input logic [31:0] size);
        put_word(id);
        put_word(size);
        file_bytes.push_back(8'($urandom_range(255)));
        file_bytes.push_back(8'($urandom_range(255)));
        file_bytes.push_back(8'($urandom_range(3)));
    endtask

    task automatic start_file();
        file_bytes.delete();
        repeat (10) file_bytes.push_back(8'($urandom_range(255)));
    endtask

    // Offer one beat, idling at random first; valid stays up until accepted
    task automatic send_byte(input logic [7:0] b, input logic fs);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= b;
        i_file_start <= fs;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_file();
        foreach (file_bytes[k]) begin
            send_byte(file_bytes[k], k == 0);
        end
        files_sent++;
    endtask

    // Drop valid, let predicted beats drain, then allow the pipeline to settle
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        for (int w = 0; pending != 0 && w < DRAIN_LIMIT; w++) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_max_frames(input logic [3:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    // Mostly well-formed files; a few cut short, stopped by size zero or oversized
    task automatic build_random_file();
        int          frames;
        int          r;
        int          cut;
        logic [31:0] id;
        logic [31:0] size;
        start_file();
        frames = $urandom_range(1, 9);
        for (int f = 0; f < frames; f++) begin
            r = $urandom_range(99);
            if (r < 60) begin
                id = KIND_IDS[$urandom_range(KIND_COUNT - 1)];
            end else if (r < 75) begin
                id = KIND_IDS[$urandom_range(KIND_COUNT - 1)] ^ (32'h1 << $urandom_range(31));
            end else if (r < 85) begin
                id = $urandom;
                id[8*$urandom_range(3) +: 8] = 8'h00;
            end else begin
                id = $urandom;
            end
            r = $urandom_range(99);
            if (r < 4) begin
                // size zero stops the parse; trailing bytes are ignored
                put_word(id);
                put_word(32'h0);
                repeat ($urandom_range(5)) file_bytes.push_back(8'($urandom_range(255)));
                break;
            end
            if (r < 8) begin
                // oversized frame, truncated by the next file start
                size = $urandom | 32'h0000_1000;
                put_frame_head(id, size);
                repeat ($urandom_range(3, 30)) file_bytes.push_back(text_char());
                break;
            end
            size = (r < 25) ? 32'($urandom_range(13, 48)) : 32'($urandom_range(1, 12));
            put_frame_head(id, size);
            repeat (size - 1) file_bytes.push_back(text_char());
        end
        if ($urandom_range(99) < 10) begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end
    endtask

    initial begin : stimulus
        int chunk_bytes;
        logic [3:0] mf;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one-byte frame, last char, zero stop, empty text,
        // short comment, unknown ID, ID with zero byte, frame limit
        start_file();
        put_frame_head(ID_TIT2, 32'd1);
        put_frame_head(ID_TPE1, 32'd4);
        put_text("abc");
        put_frame_head(ID_TALB, 32'd5);
        put_text("ab");
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        put_frame_head(ID_TCON, 32'd2);
        file_bytes.push_back(8'h00);
        put_frame_head(ID_COMM, 32'd5);
        put_text("eng");
        file_bytes.push_back(8'h00);
        put_frame_head(ID_TXXX, 32'd3);
        put_text("zz");
        put_frame_head({8'h54, 8'h00, 8'h54, 8'h32}, 32'd2);
        file_bytes.push_back(8'h41);
        put_frame_head(ID_TYER, 32'd3);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h01);
        put_frame_head(ID_COMM, 32'd3);
        send_file();

        // Truncated title, then a comment with text, a size-zero stop and trailing bytes
        start_file();
        put_frame_head(ID_TIT2, 32'd20);
        put_text("cutoff");
        send_file();
        start_file();
        put_frame_head(ID_COMM, 32'd8);
        put_text("eng");
        file_bytes.push_back(8'h00);
        put_text("xyz");
        put_word(ID_TIT2);
        put_word(32'h0);
        put_text("junk");
        send_file();

        // Zero frame limit: nothing is read
        write_max_frames(4'd0);
        start_file();
        put_frame_head(ID_TIT2, 32'd2);
        put_text("Q");
        send_file();

        // Random files across idle patterns and frame limits
        for (int c = 0; c < CHUNKS; c++) begin
            if (c < 4) begin
                send_idle = 33;
                recv_idle = 83;
            end else if (c < 8) begin
                send_idle = 83;
                recv_idle = 33;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (c == 0 || c == CHUNKS - 1) begin
                mf = 4'd1;
            end else if (c == 1 || c == 8) begin
                mf = COUNT_MAX;
            end else begin
                mf = 4'($urandom_range(2, 14));
            end
            write_max_frames(mf);
            if (c == 9) begin
                hold_arm = 1'b1;
            end
            chunk_bytes = 0;
            while (chunk_bytes < CHUNK_BYTES) begin
                build_random_file();
                send_file();
                chunk_bytes += file_bytes.size();
            end
        end

        drain();
        $display("Fed %0d bytes in %0d files under %0d frame-limit settings;",
                 bytes_sent, files_sent, cfg_writes);
        $display("checked %0d text beats, %0d mismatches, %0d still outstanding.",
                 checked, mismatches, pending);
        if (mismatches == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
